// ----- rtl/cvod_pkg.sv -----
// Shared widths, counts and tally limits for the cell voltage outlier detector.
`default_nettype none
package cvod_pkg;

  localparam int CELL_COUNT = 4;
  localparam int IN_CELLS   = 4;
  localparam int TALLY_BITS = 16;

  localparam int PACK_W  = 18;
  localparam int CELL_W  = 16;
  localparam int STAT_W  = 16;
  localparam int CNT_W   = $clog2(CELL_COUNT + 1);
  localparam int DIST_W  = CELL_W + CNT_W;
  localparam int SUM_W   = DIST_W + CNT_W;
  localparam int WIDE_W  = SUM_W + CNT_W;
  localparam int CMP_W   = PACK_W + CNT_W;

  typedef logic [CELL_W-1:0]            cell_mv_t;
  typedef logic [PACK_W-1:0]            pack_mv_t;
  typedef logic [DIST_W-1:0]            dist_t;
  typedef logic [SUM_W-1:0]             dsum_t;
  typedef logic signed [TALLY_BITS-1:0] tally_t;
  typedef logic signed [STAT_W-1:0]     status_t;
  typedef logic [IN_CELLS-1:0]          mask_t;

  localparam tally_t TALLY_MAX = {1'b0, {(TALLY_BITS-1){1'b1}}};
  localparam tally_t TALLY_MIN = {1'b1, {(TALLY_BITS-1){1'b0}}};

endpackage
`default_nettype wire

// ----- rtl/cell_voltage_outlier_detector.sv -----
// Cell voltage outlier detector: distance spread test and saturating per-cell tallies.
`default_nettype none
// One transaction in, one transaction out. An input is registered, then the
// distance network, spread test and tally update run combinationally into
// the result register, and a new sample is taken every cycle while the result
// side keeps up. The per-cell tallies reset to zero and move by one on each
// sample that moves that cell, saturating at the signed tally limits.
module cell_voltage_outlier_detector (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire cvod_pkg::pack_mv_t      in_pack_mv,
  input  wire cvod_pkg::cell_mv_t      in_cell0_mv,
  input  wire cvod_pkg::cell_mv_t      in_cell1_mv,
  input  wire cvod_pkg::cell_mv_t      in_cell2_mv,
  input  wire cvod_pkg::cell_mv_t      in_cell3_mv,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_outlier_seen,
  output cvod_pkg::mask_t              out_moved_mask,
  output cvod_pkg::status_t            out_status0,
  output cvod_pkg::status_t            out_status1,
  output cvod_pkg::status_t            out_status2,
  output cvod_pkg::status_t            out_status3
);
  import cvod_pkg::*;

  logic      s1_valid_r;
  pack_mv_t  s1_pack_r;
  cell_mv_t  s1_cell_r [IN_CELLS];

  logic      out_valid_r;
  logic      out_seen_r;
  mask_t     out_mask_r;
  status_t   out_stat_r [IN_CELLS];

  tally_t    tally_r   [CELL_COUNT];
  tally_t    tally_nxt [CELL_COUNT];

  cell_mv_t  cell_v [CELL_COUNT];
  dist_t     dist_v [CELL_COUNT];
  dist_t     dmin;
  dist_t     dmax;
  dsum_t     dsum;
  logic      seen;
  logic      move   [CELL_COUNT];
  logic      above  [CELL_COUNT];
  mask_t     mask;

  logic      adv_out;
  logic      s1_fire;
  logic      in_fire;

  assign adv_out  = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && adv_out;
  assign in_stall = s1_valid_r && !adv_out;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    dist_t d;
    for (int i = 0; i < CELL_COUNT; i++) begin
      cell_v[i] = (i < IN_CELLS) ? s1_cell_r[i] : '0;
    end
    dmin = '1;
    dmax = '0;
    dsum = '0;
    for (int i = 0; i < CELL_COUNT; i++) begin
      d = '0;
      for (int j = 0; j < CELL_COUNT; j++) begin
        d = d + DIST_W'((cell_v[i] > cell_v[j]) ? (cell_v[i] - cell_v[j])
                                                  : (cell_v[j] - cell_v[i]));
      end
      dist_v[i] = d;
      dsum = dsum + SUM_W'(d);
      if (d > dmax) begin
        dmax = d;
      end
      if (d < dmin) begin
        dmin = d;
      end
    end
    seen = (WIDE_W'(dmax - dmin) * WIDE_W'(CELL_COUNT)) > WIDE_W'(dsum);
    mask = '0;
    for (int i = 0; i < CELL_COUNT; i++) begin
      move[i]  = seen && ({1'b0, dist_v[i], 1'b0} > ({2'b00, dmax} + {2'b00, dmin}));
      above[i] = (CMP_W'(cell_v[i]) * CMP_W'(CELL_COUNT)) > CMP_W'(s1_pack_r);
      tally_nxt[i] = tally_r[i];
      if (move[i]) begin
        if (above[i]) begin
          if (tally_r[i] != TALLY_MAX) begin
            tally_nxt[i] = tally_r[i] + tally_t'(1);
          end
        end else begin
          if (tally_r[i] != TALLY_MIN) begin
            tally_nxt[i] = tally_r[i] - tally_t'(1);
          end
        end
      end
      if (i < IN_CELLS) begin
        mask[i] = move[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CELL_COUNT; i++) begin
        tally_r[i] <= '0;
      end
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        for (int i = 0; i < CELL_COUNT; i++) begin
          tally_r[i] <= tally_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pack_r    <= in_pack_mv;
      s1_cell_r[0] <= in_cell0_mv;
      s1_cell_r[1] <= in_cell1_mv;
      s1_cell_r[2] <= in_cell2_mv;
      s1_cell_r[3] <= in_cell3_mv;
    end
    if (s1_fire) begin
      out_seen_r <= seen;
      out_mask_r <= mask;
      for (int i = 0; i < IN_CELLS; i++) begin
        out_stat_r[i] <= (i < CELL_COUNT) ? STAT_W'(tally_nxt[i]) : '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_outlier_seen = out_seen_r;
  assign out_moved_mask   = out_mask_r;
  assign out_status0      = out_stat_r[0];
  assign out_status1      = out_stat_r[1];
  assign out_status2      = out_stat_r[2];
  assign out_status3      = out_stat_r[3];

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty input register");

  a_tally_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> (tally_r[0] == $past(tally_r[0])) && (tally_r[1] == $past(tally_r[1]))
                 && (tally_r[2] == $past(tally_r[2])) && (tally_r[3] == $past(tally_r[3])))
    else $error("tally moved without a transaction");

  a_mask_needs_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_mask_r != '0)) |-> out_seen_r)
    else $error("cell moved while spread test failed");

  a_seen_moves_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_seen_r) |-> (out_mask_r != '0))
    else $error("spread test passed but no cell moved");

endmodule
`default_nettype wire
